// ----- hw/rtl/nsp_pkg.sv -----
// Shared types and constants of the network information section parser.
package nsp_pkg;

  localparam logic [7:0] TAG_NAME = 8'h40;
  localparam logic [7:0] TAG_TERR = 8'h5A;
  localparam logic [7:0] TABLE_ID_RESET = 8'd64;
  localparam int unsigned POS_MAX = 4095;

  // register index of the accepted table id
  localparam logic REG_TABLE_ID = 1'b0;

  typedef enum logic {
    KIND_NAME    = 1'b0,
    KIND_SUMMARY = 1'b1
  } nsp_kind_e;

  typedef struct packed {
    nsp_kind_e   kind;
    logic [7:0]  name_char;
    logic        name_first;
    logic        table_matched;
    logic [15:0] network_ident;
    logic [2:0]  bandwidth;
    logic [1:0]  constellation;
    logic [2:0]  code_rate;
    logic [1:0]  guard;
    logic        delivery_found;
  } nsp_result_t;

endpackage

// ----- hw/rtl/nsp_cfg_regs.sv -----
// APB register file holding the accepted table id.
module nsp_cfg_regs import nsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  table_id_o
);

  logic [7:0] table_id_q;
  logic       reg_sel;
  logic       wr_en;

  assign reg_sel = (paddr[2] == REG_TABLE_ID);
  assign wr_en   = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {24'd0, table_id_q} : 32'd0;
  assign table_id_o = table_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_id_q <= TABLE_ID_RESET;
    end else if (wr_en) begin
      table_id_q <= pwdata[7:0];
    end
  end

endmodule

// ----- hw/rtl/nsp_parser.sv -----
// Section walker: parse state, latched fields and the result of one byte.
module nsp_parser import nsp_pkg::*; #(
  parameter int unsigned MAX_SECTION_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        first_i,
  input  logic        last_i,
  input  logic [7:0]  table_id_i,
  output logic        res_valid_o,
  output nsp_result_t res_o
);

  localparam int unsigned POS_LIMIT =
      (MAX_SECTION_BYTES > POS_MAX) ? POS_MAX : MAX_SECTION_BYTES;

  typedef enum logic [2:0] {
    PH_HDR    = 3'd0,
    PH_NET    = 3'd1,
    PH_TSLEN  = 3'd2,
    PH_TSHDR  = 3'd3,
    PH_TSDESC = 3'd4,
    PH_DONE   = 3'd5,
    PH_WAIT   = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] pre;
    logic [7:0] off;
    logic [7:0] tag;
    logic [7:0] len;
  } walk_t;

  function automatic walk_t walk_desc(input logic [7:0] off, input logic [7:0] tag,
                                      input logic [7:0] len, input logic [7:0] b);
    walk_t w;
    logic  done;
    w.pre = off;
    w.tag = tag;
    w.len = len;
    w.off = off;
    done  = 1'b0;
    if (off == 8'd0) begin
      w.tag = b;
    end else if (off == 8'd1) begin
      w.len = b;
      done  = (b == 8'd0);
    end else begin
      w.len = len - 8'd1;
      done  = (w.len == 8'd0);
    end
    if (done) begin
      w.off = 8'd0;
    end else if (off < 8'd255) begin
      w.off = off + 8'd1;
    end
    return w;
  endfunction

  phase_e      phase_q, phase_d;
  logic [11:0] pos_q, pos_d;
  logic [11:0] net_rem_q, net_rem_d;
  logic [11:0] ts_rem_q, ts_rem_d;
  logic [11:0] desc_rem_q, desc_rem_d;
  logic [7:0]  tag_q, tag_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  off_q, off_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] net_id_q, net_id_d;
  logic [2:0]  bw_q, bw_d;
  logic [1:0]  con_q, con_d;
  logic [2:0]  cr_q, cr_d;
  logic [1:0]  gi_q, gi_d;
  logic        tbl_ok_q, tbl_ok_d;
  logic        found_q, found_d;
  logic        emit, emit_first;
  walk_t       walk;

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    net_rem_d  = net_rem_q;
    ts_rem_d   = ts_rem_q;
    desc_rem_d = desc_rem_q;
    tag_d      = tag_q;
    len_d      = len_q;
    off_d      = off_q;
    held_d     = held_q;
    net_id_d   = net_id_q;
    bw_d       = bw_q;
    con_d      = con_q;
    cr_d       = cr_q;
    gi_d       = gi_q;
    tbl_ok_d   = tbl_ok_q;
    found_d    = found_q;
    emit       = 1'b0;
    emit_first = 1'b0;
    walk       = '0;

    if (first_i) begin
      pos_d      = '0;
      phase_d    = PH_HDR;
      net_rem_d  = '0;
      ts_rem_d   = '0;
      desc_rem_d = '0;
      off_d      = '0;
      tbl_ok_d   = 1'b0;
      found_d    = 1'b0;
    end

    if (phase_d != PH_WAIT && pos_d < 12'(POS_LIMIT)) begin
      case (phase_d)
        PH_HDR: begin
          if (pos_d == 12'd0) begin
            tbl_ok_d = (byte_i == table_id_i);
          end else if (pos_d == 12'd3 || pos_d == 12'd8) begin
            held_d = byte_i;
          end else if (pos_d == 12'd4) begin
            net_id_d = {held_d, byte_i};
          end else if (pos_d == 12'd9) begin
            net_rem_d = {held_d[3:0], byte_i};
            off_d     = '0;
            if (!tbl_ok_d) begin
              phase_d = PH_DONE;
            end else begin
              phase_d = (net_rem_d != 12'd0) ? PH_NET : PH_TSLEN;
            end
          end
        end
        PH_NET: begin
          walk  = walk_desc(off_d, tag_d, len_d, byte_i);
          tag_d = walk.tag;
          len_d = walk.len;
          off_d = walk.off;
          if (walk.pre >= 8'd2 && tag_d == TAG_NAME) begin
            emit       = 1'b1;
            emit_first = (walk.pre == 8'd2);
          end
          net_rem_d = net_rem_d - 12'd1;
          if (net_rem_d == 12'd0) begin
            phase_d = PH_TSLEN;
            off_d   = '0;
          end
        end
        PH_TSLEN: begin
          if (off_d == 8'd0) begin
            held_d = byte_i;
            off_d  = 8'd1;
          end else begin
            ts_rem_d = {held_d[3:0], byte_i};
            off_d    = '0;
            phase_d  = (ts_rem_d != 12'd0) ? PH_TSHDR : PH_DONE;
          end
        end
        PH_TSHDR: begin
          if (off_d == 8'd4) begin
            held_d = byte_i;
          end else if (off_d == 8'd5) begin
            desc_rem_d = {held_d[3:0], byte_i};
          end
          off_d = off_d + 8'd1;
          if (off_d >= 8'd6) begin
            off_d   = '0;
            phase_d = (desc_rem_d != 12'd0) ? PH_TSDESC : PH_TSHDR;
          end
          ts_rem_d = ts_rem_d - 12'd1;
          if (ts_rem_d == 12'd0) begin
            phase_d = PH_DONE;
            off_d   = '0;
          end
        end
        PH_TSDESC: begin
          walk  = walk_desc(off_d, tag_d, len_d, byte_i);
          tag_d = walk.tag;
          len_d = walk.len;
          off_d = walk.off;
          if (tag_d == TAG_TERR) begin
            if (walk.pre == 8'd0) begin
              found_d = 1'b1;
            end else if (walk.pre == 8'd6) begin
              bw_d = byte_i[7:5];
            end else if (walk.pre == 8'd7) begin
              con_d = byte_i[7:6];
              cr_d  = byte_i[2:0];
            end else if (walk.pre == 8'd8) begin
              gi_d = byte_i[4:3];
            end
          end
          desc_rem_d = desc_rem_d - 12'd1;
          ts_rem_d   = ts_rem_d - 12'd1;
          if (desc_rem_d == 12'd0) begin
            off_d   = '0;
            phase_d = PH_TSHDR;
          end
          if (ts_rem_d == 12'd0) begin
            off_d   = '0;
            phase_d = PH_DONE;
          end
        end
        default: begin
        end
      endcase
      pos_d = pos_d + 12'd1;
    end

    // after the last word everything waits for the next start mark
    if (last_i) begin
      phase_d = PH_WAIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR;
      pos_q      <= '0;
      net_rem_q  <= '0;
      ts_rem_q   <= '0;
      desc_rem_q <= '0;
      tag_q      <= '0;
      len_q      <= '0;
      off_q      <= '0;
      held_q     <= '0;
      net_id_q   <= '0;
      bw_q       <= '0;
      con_q      <= '0;
      cr_q       <= '0;
      gi_q       <= '0;
      tbl_ok_q   <= 1'b0;
      found_q    <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      net_rem_q  <= net_rem_d;
      ts_rem_q   <= ts_rem_d;
      desc_rem_q <= desc_rem_d;
      tag_q      <= tag_d;
      len_q      <= len_d;
      off_q      <= off_d;
      held_q     <= held_d;
      net_id_q   <= net_id_d;
      bw_q       <= bw_d;
      con_q      <= con_d;
      cr_q       <= cr_d;
      gi_q       <= gi_d;
      tbl_ok_q   <= tbl_ok_d;
      found_q    <= found_d;
    end
  end

  assign res_valid_o = emit || last_i;

  always_comb begin
    res_o.kind           = last_i ? KIND_SUMMARY : KIND_NAME;
    res_o.name_char      = last_i ? 8'd0 : byte_i;
    res_o.name_first     = !last_i && emit_first;
    res_o.table_matched  = tbl_ok_d;
    res_o.network_ident  = net_id_d;
    res_o.bandwidth      = bw_d;
    res_o.constellation  = con_d;
    res_o.code_rate      = cr_d;
    res_o.guard          = gi_d;
    res_o.delivery_found = found_d;
  end

endmodule

// ----- hw/rtl/nit_section_parser_top.sv -----
// Top level of the network information section parser.
//
//  channel   direction  handshake               payload
//  in        sink       in_valid_i/in_ready_o   section_byte, first/last_of_section
//  out       source     out_valid_o/out_ready_i result_kind .. delivery_found
//  cfg       APB slave  psel/penable/pready     accepted_table_id at address 0
//
// One word per cycle sustained while no held result stalls the input register. A word is
// taken into the input register; a single pass of walker logic feeds the result register.
// Reset clears the input and result valids, the parse state and the latched fields.
// A held result stalls the input register only when the next word also makes a result.
module nit_section_parser_top import nsp_pkg::*; #(
  parameter int unsigned MAX_SECTION_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  section_byte_i,
  input  logic        first_of_section_i,
  input  logic        last_of_section_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  name_char_o,
  output logic        name_first_o,
  output logic        table_matched_o,
  output logic [15:0] network_ident_o,
  output logic [2:0]  bandwidth_code_o,
  output logic [1:0]  constellation_code_o,
  output logic [2:0]  code_rate_code_o,
  output logic [1:0]  guard_code_o,
  output logic        delivery_found_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        first_q;
  logic        last_q;
  logic        out_valid_q;
  nsp_result_t out_q;
  nsp_result_t res;
  logic        res_valid;
  logic        has_res;
  logic        advance;
  logic        load_out;
  logic [7:0]  table_id;

  nsp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .table_id_o (table_id)
  );

  nsp_parser #(
    .MAX_SECTION_BYTES (MAX_SECTION_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (byte_q),
    .first_i     (first_q),
    .last_i      (last_q),
    .table_id_i  (table_id),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign has_res    = in_valid_q && res_valid;
  assign advance    = in_valid_q && (!has_res || !out_valid_q || out_ready_i);
  assign load_out   = advance && has_res;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= section_byte_i;
      first_q <= first_of_section_i;
      last_q  <= last_of_section_i;
    end
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign result_kind_o        = out_q.kind;
  assign name_char_o          = out_q.name_char;
  assign name_first_o         = out_q.name_first;
  assign table_matched_o      = out_q.table_matched;
  assign network_ident_o      = out_q.network_ident;
  assign bandwidth_code_o     = out_q.bandwidth;
  assign constellation_code_o = out_q.constellation;
  assign code_rate_code_o     = out_q.code_rate;
  assign guard_code_o         = out_q.guard;
  assign delivery_found_o     = out_q.delivery_found;

  // a summary never carries a name character
  a_summary_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_SUMMARY |-> out_q.name_char == 8'd0 && !out_q.name_first)
    else $error("summary word carries name data");

  // a held result is not overwritten
  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_q))
    else $error("pending result lost or changed");

  // an accepted word always lands in the input register
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> in_valid_q)
    else $error("accepted word not captured");

  // an empty input register never back-pressures
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input stalled while empty");

endmodule

// ----- tb/nit_section_parser_checker.sv -----
// Checker for the section parser: predicts results from the accepted words and compares.
`timescale 1ns / 1ps

module nit_section_parser_checker import nsp_pkg::*; #(
  parameter int unsigned MAX_SECTION_BYTES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  section_byte_i,
  input  logic        first_of_section_i,
  input  logic        last_of_section_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        result_kind_i,
  input  logic [7:0]  name_char_i,
  input  logic        name_first_i,
  input  logic        table_matched_i,
  input  logic [15:0] network_ident_i,
  input  logic [2:0]  bandwidth_code_i,
  input  logic [1:0]  constellation_code_i,
  input  logic [2:0]  code_rate_code_i,
  input  logic [1:0]  guard_code_i,
  input  logic        delivery_found_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned words_o,
  output int unsigned names_o,
  output int unsigned summaries_o,
  output int unsigned deliveries_o
);

  localparam int unsigned POS_LIMIT =
      (MAX_SECTION_BYTES > POS_MAX) ? POS_MAX : MAX_SECTION_BYTES;
  localparam logic [2:0] TABLE_ID_ADDR = {REG_TABLE_ID, 2'b00};

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_NET_LOOP,
    PH_TS_LEN,
    PH_TS_ENTRY,
    PH_TS_DESC,
    PH_TRAILER,
    PH_IDLE
  } parse_phase_e;

  // predictor state
  logic [7:0]   table_id;
  logic [11:0]  pos;
  parse_phase_e phase;
  logic [11:0]  net_left, ts_left, entry_left;
  logic [7:0]   tag, desc_len, desc_off, hi_byte;
  logic [15:0]  net_id;
  logic [2:0]   bw, rate;
  logic [1:0]   modu, guard_iv;
  logic         tid_ok, terr_seen;

  nsp_result_t due_results[$];
  int unsigned fail_count = 0;
  int unsigned due_count = 0;
  int unsigned words = 0;
  int unsigned names = 0;
  int unsigned summaries = 0;
  int unsigned deliveries = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = due_count;
  assign words_o      = words;
  assign names_o      = names;
  assign summaries_o  = summaries;
  assign deliveries_o = deliveries;

  // one byte through the descriptor walker; returns the offset it sat at
  function automatic logic [7:0] walk_descriptor(input logic [7:0] b);
    logic [7:0] pre;
    logic       done;
    pre  = desc_off;
    done = 1'b0;
    if (pre == 8'd0) begin
      tag = b;
    end else if (pre == 8'd1) begin
      desc_len = b;
      done = (b == 8'd0);
    end else begin
      desc_len = desc_len - 8'd1;
      done = (desc_len == 8'd0);
    end
    if (done) desc_off = 8'd0;
    else if (desc_off < 8'd255) desc_off = desc_off + 8'd1;
    return pre;
  endfunction

  function automatic logic parse_section_byte(input logic [7:0] b, input logic first,
                                              input logic last, output nsp_result_t r);
    logic [7:0] pre;
    logic       emit, lead;
    emit = 1'b0;
    lead = 1'b0;
    r    = '0;
    if (first) begin
      pos = '0; phase = PH_HEADER;
      net_left = '0; ts_left = '0; entry_left = '0;
      desc_off = '0; tid_ok = 1'b0; terr_seen = 1'b0;
    end
    if (phase != PH_IDLE && pos < POS_LIMIT) begin
      case (phase)
        PH_HEADER: begin
          if (pos == 12'd0) tid_ok = (b == table_id);
          else if (pos == 12'd3 || pos == 12'd8) hi_byte = b;
          else if (pos == 12'd4) net_id = {hi_byte, b};
          else if (pos == 12'd9) begin
            net_left = {hi_byte[3:0], b};
            desc_off = '0;
            if (!tid_ok) phase = PH_TRAILER;
            else phase = (net_left != 0) ? PH_NET_LOOP : PH_TS_LEN;
          end
        end
        PH_NET_LOOP: begin
          pre = walk_descriptor(b);
          if (pre >= 8'd2 && tag == TAG_NAME) begin
            emit = 1'b1;
            lead = (pre == 8'd2);
          end
          net_left = net_left - 12'd1;
          if (net_left == 0) begin
            phase = PH_TS_LEN;
            desc_off = '0;
          end
        end
        PH_TS_LEN: begin
          if (desc_off == 8'd0) begin
            hi_byte = b;
            desc_off = 8'd1;
          end else begin
            ts_left = {hi_byte[3:0], b};
            desc_off = '0;
            phase = (ts_left != 0) ? PH_TS_ENTRY : PH_TRAILER;
          end
        end
        PH_TS_ENTRY: begin
          if (desc_off == 8'd4) hi_byte = b;
          else if (desc_off == 8'd5) entry_left = {hi_byte[3:0], b};
          desc_off = desc_off + 8'd1;
          if (desc_off >= 8'd6) begin
            desc_off = '0;
            phase = (entry_left != 0) ? PH_TS_DESC : PH_TS_ENTRY;
          end
          ts_left = ts_left - 12'd1;
          if (ts_left == 0) begin
            phase = PH_TRAILER;
            desc_off = '0;
          end
        end
        PH_TS_DESC: begin
          pre = walk_descriptor(b);
          if (tag == TAG_TERR) begin
            // payload starts at offset 2; bandwidth sits at offset 6, modulation at 7, guard at 8
            if (pre == 8'd0) terr_seen = 1'b1;
            else if (pre == 8'd6) bw = b[7:5];
            else if (pre == 8'd7) begin
              modu = b[7:6];
              rate = b[2:0];
            end else if (pre == 8'd8) guard_iv = b[4:3];
          end
          entry_left = entry_left - 12'd1;
          ts_left = ts_left - 12'd1;
          if (entry_left == 0) begin
            desc_off = '0;
            phase = PH_TS_ENTRY;
          end
          if (ts_left == 0) begin
            desc_off = '0;
            phase = PH_TRAILER;
          end
        end
        default: ;
      endcase
      pos = pos + 12'd1;
    end
    if (!last && !emit) return 1'b0;
    r.kind           = last ? KIND_SUMMARY : KIND_NAME;
    r.name_char      = last ? 8'd0 : b;
    r.name_first     = !last && lead;
    r.table_matched  = tid_ok;
    r.network_ident  = net_id;
    r.bandwidth      = bw;
    r.constellation  = modu;
    r.code_rate      = rate;
    r.guard          = guard_iv;
    r.delivery_found = terr_seen;
    if (last) phase = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic string show(input nsp_result_t r);
    return $sformatf("kind=%0d char=%02h first=%0d match=%0d net=%04h bw=%0d con=%0d cr=%0d gi=%0d found=%0d",
                     r.kind, r.name_char, r.name_first, r.table_matched, r.network_ident,
                     r.bandwidth, r.constellation, r.code_rate, r.guard, r.delivery_found);
  endfunction

  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    nsp_result_t got, want, fresh;
    if (!rst_ni) begin
      table_id = TABLE_ID_RESET;
      pos = '0; phase = PH_HEADER;
      net_left = '0; ts_left = '0; entry_left = '0;
      tag = '0; desc_len = '0; desc_off = '0; hi_byte = '0;
      net_id = '0; bw = '0; modu = '0; rate = '0; guard_iv = '0;
      tid_ok = 1'b0; terr_seen = 1'b0;
      due_results.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.kind           = nsp_kind_e'(result_kind_i);
        got.name_char      = name_char_i;
        got.name_first     = name_first_i;
        got.table_matched  = table_matched_i;
        got.network_ident  = network_ident_i;
        got.bandwidth      = bandwidth_code_i;
        got.constellation  = constellation_code_i;
        got.code_rate      = code_rate_code_i;
        got.guard          = guard_code_i;
        got.delivery_found = delivery_found_i;
        if (due_results.size() == 0) begin
          flag_failure($sformatf("result with nothing expected: %s", show(got)));
        end else begin
          want = due_results.pop_front();
          if (got !== want)
            flag_failure($sformatf("result mismatch\n  expected %s\n  actual   %s",
                                   show(want), show(got)));
          if (got.kind == KIND_SUMMARY) begin
            summaries++;
            if (got.delivery_found) deliveries++;
          end else begin
            names++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        words++;
        if (parse_section_byte(section_byte_i, first_of_section_i, last_of_section_i, fresh))
          due_results.push_back(fresh);
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == TABLE_ID_ADDR)
        table_id = pwdata_i[7:0];
    end
    due_count = due_results.size();
  end

endmodule

// ----- tb/nit_section_parser_top_tb.sv -----
// Testbench top for the section parser: section stimulus, result sink and verdict.
`timescale 1ns / 1ps

module nit_section_parser_top_tb;
  import nsp_pkg::*;

  localparam int unsigned SECTION_CAP = 96;   // small cap so overlong sections are cheap
  localparam int unsigned WATCHDOG = 400000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PHASE_WORDS = 270;
  localparam logic [2:0] TABLE_ID_ADDR = {REG_TABLE_ID, 2'b00};

  // opening words: {first, last, byte}
  localparam logic [9:0] OPENING [22] = '{
    // no start mark after reset: parsed from byte 0, table id 0x40
    10'h040, 10'h0F0, 10'h00C, 10'h0FF, 10'h0FF, 10'h000, 10'h000, 10'h000,
    10'h0F0, 10'h005,
    // empty name descriptor, then a name whose only byte is the last one
    10'h040, 10'h000, 10'h040, 10'h001, 10'h141,
    // stray bytes after the last one, ignored
    10'h000, 10'h0FF,
    // foreign table id: network id still latched
    10'h200, 10'h001, 10'h002, 10'h012, 10'h134
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  section_byte_i = 8'd0;
  logic        first_of_section_i = 1'b0;
  logic        last_of_section_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        result_kind_o;
  logic [7:0]  name_char_o;
  logic        name_first_o;
  logic        table_matched_o;
  logic [15:0] network_ident_o;
  logic [2:0]  bandwidth_code_o;
  logic [1:0]  constellation_code_o;
  logic [2:0]  code_rate_code_o;
  logic [1:0]  guard_code_o;
  logic        delivery_found_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count, pending, words, names, summaries, deliveries;
  int unsigned cycles = 0;
  int unsigned sent_words = 0;
  int          sink_wait = 0;
  logic        sink_calm = 1'b0;
  logic        src_calm = 1'b0;
  logic [7:0]  last_tid = TABLE_ID_RESET;
  logic [7:0]  section_q[$], net_q[$], ts_q[$], desc_q[$];

  nit_section_parser_top #(.MAX_SECTION_BYTES(SECTION_CAP)) uut (.*);

  nit_section_parser_checker #(.MAX_SECTION_BYTES(SECTION_CAP)) checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o),
    .section_byte_i, .first_of_section_i, .last_of_section_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .result_kind_i(result_kind_o), .name_char_i(name_char_o), .name_first_i(name_first_o),
    .table_matched_i(table_matched_o), .network_ident_i(network_ident_o),
    .bandwidth_code_i(bandwidth_code_o), .constellation_code_i(constellation_code_o),
    .code_rate_code_i(code_rate_code_o), .guard_code_i(guard_code_o),
    .delivery_found_i(delivery_found_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending), .words_o(words), .names_o(names),
    .summaries_o(summaries), .deliveries_o(deliveries)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == WATCHDOG) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("nit_section_parser_top_tb: errors");
      $finish;
    end
  end

  // result sink: random stall after each taken word, with calm stretches
  always @(posedge clk_i or negedge rst_ni) begin
    int stall;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_wait <= 0;
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      out_ready_i <= (sink_wait == 1);
    end else if (out_ready_i && out_valid_o) begin
      if ($urandom_range(0, 29) == 0) sink_calm <= !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, 5);
      sink_wait <= stall;
      out_ready_i <= (stall == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // valid is only lowered when a gap is drawn, so it never drops between back-to-back words
  task automatic send_word(input logic [7:0] b, input logic first, input logic last);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    section_byte_i <= b;
    first_of_section_i <= first;
    last_of_section_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sent_words++;
  endtask

  // stop sending and wait for every outstanding result, then let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_table_id(input logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TABLE_ID_ADDR;
    pwdata <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    last_tid = v;
  endtask

  task automatic make_descriptor(input logic [7:0] tag, input int len);
    desc_q.delete();
    desc_q.push_back(tag);
    desc_q.push_back(8'(len));
    repeat (len) desc_q.push_back(8'($urandom));
  endtask

  // well-formed section unless skew, which corrupts the loop lengths
  task automatic build_section(input logic [7:0] tid, input logic skew);
    logic [7:0]  ent_q[$];
    logic [11:0] net_len, ts_len, ent_len;
    logic [15:0] ident;
    net_q.delete();
    ts_q.delete();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0, 1: make_descriptor(TAG_NAME, $urandom_range(0, 10));
        2: make_descriptor(8'($urandom), $urandom_range(0, 5));
        default: make_descriptor(TAG_TERR, 11);
      endcase
      net_q = {net_q, desc_q};
    end
    repeat ($urandom_range(0, 2)) begin
      ent_q.delete();
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 2) != 0)
          make_descriptor(TAG_TERR, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 11);
        else
          make_descriptor(8'($urandom), $urandom_range(0, 4));
        ent_q = {ent_q, desc_q};
      end
      ent_len = 12'(ent_q.size());
      if (skew && $urandom_range(0, 2) == 0) ent_len = 12'($urandom);
      repeat (4) ts_q.push_back(8'($urandom));
      ts_q.push_back({4'($urandom), ent_len[11:8]});
      ts_q.push_back(ent_len[7:0]);
      ts_q = {ts_q, ent_q};
    end
    net_len = 12'(net_q.size());
    ts_len = 12'(ts_q.size());
    if (skew) begin
      net_len = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                             : 12'($urandom_range(0, net_q.size() + 6));
      ts_len = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                            : 12'($urandom_range(0, ts_q.size() + 6));
    end
    case ($urandom_range(0, 5))
      0: ident = 16'h0000;
      1: ident = 16'hFFFF;
      default: ident = 16'($urandom);
    endcase
    section_q.delete();
    section_q.push_back(tid);
    repeat (2) section_q.push_back(8'($urandom));
    section_q.push_back(ident[15:8]);
    section_q.push_back(ident[7:0]);
    repeat (3) section_q.push_back(8'($urandom));
    section_q.push_back({4'($urandom), net_len[11:8]});
    section_q.push_back(net_len[7:0]);
    section_q = {section_q, net_q};
    section_q.push_back({4'($urandom), ts_len[11:8]});
    section_q.push_back(ts_len[7:0]);
    section_q = {section_q, ts_q};
    repeat (4) section_q.push_back(8'($urandom));
    // now and then run well past the byte cap
    if ($urandom_range(0, 11) == 0) repeat ($urandom_range(30, 80)) section_q.push_back(8'($urandom));
  endtask

  // occasionally cut short, or sent without its start or end mark
  task automatic send_section();
    int n;
    logic no_first, no_last;
    n = section_q.size();
    if ($urandom_range(0, 11) == 0) n = $urandom_range(1, n);
    no_first = ($urandom_range(0, 15) == 0);
    no_last = ($urandom_range(0, 15) == 0);
    src_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++)
      send_word(section_q[i], (i == 0) && !no_first, (i == n - 1) && !no_last);
  endtask

  initial begin
    logic [7:0] accepted, tid;
    int unsigned phase_start;
    int pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 22; i++) send_word(OPENING[i][7:0], OPENING[i][9], OPENING[i][8]);

    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: accepted = 8'h40;
        1: accepted = 8'h00;
        2: accepted = 8'hFF;
        default: accepted = 8'($urandom);
      endcase
      write_table_id(accepted);
      phase_start = sent_words;
      while (sent_words - phase_start < PHASE_WORDS) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // noise words with stray flags
          src_calm = 1'b0;
          repeat ($urandom_range(3, 12))
            send_word(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        end else begin
          tid = ($urandom_range(0, 4) == 0) ? 8'($urandom) : accepted;
          build_section(tid, pick == 1);
          send_section();
        end
      end
    end

    settle();
    @(negedge clk_i);
    $display("covered %0d section words, %0d name bytes and %0d summaries (%0d with delivery data)",
             words, names, summaries, deliveries);
    $display("table ids 0x40, 0x00, 0xff and 0x%02h accepted; sections cut at %0d bytes",
             last_tid, SECTION_CAP);
    if (fail_count == 0 && pending == 0) begin
      $display("nit_section_parser_top_tb: clean");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending);
      $display("nit_section_parser_top_tb: errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/nsp_pkg.sv
hw/rtl/nsp_cfg_regs.sv
hw/rtl/nsp_parser.sv
hw/rtl/nit_section_parser_top.sv
tb/nit_section_parser_checker.sv
tb/nit_section_parser_top_tb.sv
